### rtl/assert_macros.svh
// Assertion macros used by the RTL of the color converter.
// Depends on nothing; defined empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RHC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RHC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RHC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RHC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### rtl/rhc_pkg.sv
// Package of the RGB/HSV converter: widths, constants, item types, helpers.
// Depends on nothing.
package rhc_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int FIELD_W      = 16;
  localparam int SEC_W        = 12;
  localparam int QB           = (CHANNEL_BITS > FIELD_W) ? CHANNEL_BITS : FIELD_W;
  localparam int KW           = CHANNEL_BITS + SEC_W;
  localparam int NW           = KW + QB;
  localparam int LANES        = 3;

  localparam logic [31:0]        CMAX32  = 32'((64'd1 << CHANNEL_BITS) - 64'd1);
  localparam logic [KW-1:0]      CMAX_K  = KW'((64'd1 << CHANNEL_BITS) - 64'd1);
  localparam logic [KW-1:0]      K_CONST = KW'(((64'd1 << CHANNEL_BITS) - 64'd1) * 64'd3840);
  localparam logic [SEC_W-1:0]   SEC_LEN = 12'd3840;

  localparam logic [FIELD_W-1:0] HUE_SEC        = 16'd3840;
  localparam logic [FIELD_W-1:0] HUE_GREEN_BASE = 16'd7680;
  localparam logic [FIELD_W-1:0] HUE_BLUE_BASE  = 16'd15360;
  localparam logic [FIELD_W-1:0] HUE_FULL       = 16'd23040;

  localparam logic OP_TO_HSV = 1'b0;
  localparam logic OP_TO_RGB = 1'b1;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } rhc_max_e;

  typedef struct packed {
    logic               opcode;
    logic [FIELD_W-1:0] channel_a;
    logic [FIELD_W-1:0] channel_b;
    logic [FIELD_W-1:0] channel_c;
  } rhc_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_a;
    logic [FIELD_W-1:0] result_b;
    logic [FIELD_W-1:0] result_c;
  } rhc_out_t;

  // Per-item control that rides along the divider chain
  typedef struct packed {
    logic               to_rgb;
    logic               special;
    rhc_max_e           sel;
    logic               neg;
    logic [2:0]         sector;
    logic [FIELD_W-1:0] v;
  } rhc_side_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [NW-1:0] dsh;
    logic [QB-1:0] quo;
  } rhc_lane_t;

  typedef rhc_lane_t [LANES-1:0] rhc_lanes_t;

  function automatic logic [FIELD_W-1:0] clamp_ch(input logic [FIELD_W-1:0] x);
    logic [FIELD_W-1:0] r;
    r = (32'(x) > CMAX32) ? CMAX32[FIELD_W-1:0] : x;
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] sector_base(input logic [2:0] sector);
    logic [FIELD_W-1:0] r;
    case (sector)
      3'd1:    r = 16'd3840;
      3'd2:    r = 16'd7680;
      3'd3:    r = 16'd11520;
      3'd4:    r = 16'd15360;
      3'd5:    r = 16'd19200;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/rhc_prep.sv
// Front end of the converter: classify the pixel, then form dividends and divisors.
// Depends on rhc_pkg.
module rhc_prep
  import rhc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  rhc_in_t    item_i,
  output logic       valid_o,
  output rhc_lanes_t lanes_o,
  output rhc_side_t  side_o
);

  logic [FIELD_W-1:0] r, g, b, mx, mn, d, pa, pb, mag, h, s, v;
  rhc_max_e           sel;
  logic [2:0]         sector;
  logic [SEC_W-1:0]   f;
  logic [KW-1:0]      sf, st;
  logic               to_rgb;

  logic               s1_valid_q;
  logic               s1_to_rgb_q, s1_special_q, s1_neg_q;
  rhc_max_e           s1_sel_q;
  logic [2:0]         s1_sector_q;
  logic [FIELD_W-1:0] s1_v_q, s1_x_q, s1_mag_q;
  logic [KW-1:0]      s1_sf_q, s1_st_q;

  always_comb begin
    to_rgb = (item_i.opcode == OP_TO_RGB);
    r = clamp_ch(item_i.channel_a);
    g = clamp_ch(item_i.channel_b);
    b = clamp_ch(item_i.channel_c);
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (r >= mx) begin
      sel = MAX_RED;   pa = g; pb = b;
    end else if (g >= mx) begin
      sel = MAX_GREEN; pa = b; pb = r;
    end else begin
      sel = MAX_BLUE;  pa = r; pb = g;
    end
    mag = (pa < pb) ? (pb - pa) : (pa - pb);

    h = (item_i.channel_a >= HUE_FULL) ? '0 : item_i.channel_a;
    sector = 3'(h >= sector_base(3'd1)) + 3'(h >= sector_base(3'd2)) +
             3'(h >= sector_base(3'd3)) + 3'(h >= sector_base(3'd4)) +
             3'(h >= sector_base(3'd5));
    f = SEC_W'(h - sector_base(sector));
    s = g;
    v = b;
    sf = KW'(28'(s) * 28'(f));
    st = KW'(28'(s) * 28'(SEC_LEN - f));
  end

  // Stage 1: classification
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_to_rgb_q  <= to_rgb;
      s1_special_q <= to_rgb ? (s == '0) : (d == '0);
      s1_neg_q     <= (pa < pb);
      s1_sel_q     <= sel;
      s1_sector_q  <= sector;
      s1_v_q       <= to_rgb ? v : mx;
      s1_x_q       <= to_rgb ? s : d;
      s1_mag_q     <= mag;
      s1_sf_q      <= sf;
      s1_st_q      <= st;
    end
  end

  // Stage 2: multiply to form each lane's dividend and divisor
  logic [NW-1:0] num [LANES];
  logic [KW-1:0] div [LANES];

  always_comb begin
    num[0] = s1_to_rgb_q ? NW'(s1_v_q) * NW'(CMAX_K - KW'(s1_x_q))
                         : NW'(s1_x_q) * NW'(CMAX_K);
    div[0] = s1_to_rgb_q ? CMAX_K : KW'(s1_v_q);
    num[1] = s1_to_rgb_q ? NW'(s1_v_q) * NW'(K_CONST - s1_sf_q)
                         : NW'(s1_mag_q) * NW'(SEC_LEN);
    div[1] = s1_to_rgb_q ? K_CONST : KW'(s1_x_q);
    num[2] = NW'(s1_v_q) * NW'(K_CONST - s1_st_q);
    div[2] = K_CONST;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        lanes_o[l].rem <= num[l];
        lanes_o[l].dsh <= NW'(div[l]) << (QB - 1);
        lanes_o[l].quo <= '0;
      end
      side_o.to_rgb  <= s1_to_rgb_q;
      side_o.special <= s1_special_q;
      side_o.sel     <= s1_sel_q;
      side_o.neg     <= s1_neg_q;
      side_o.sector  <= s1_sector_q;
      side_o.v       <= s1_v_q;
    end
  end

endmodule

### rtl/rhc_div_cell.sv
// One cell of the divider chain: one restoring quotient bit on each lane.
// Depends on rhc_pkg.
module rhc_div_cell
  import rhc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  rhc_lanes_t lanes_i,
  input  rhc_side_t  side_i,
  output logic       valid_o,
  output rhc_lanes_t lanes_o,
  output rhc_side_t  side_o
);

  rhc_lanes_t lanes_d;
  logic       ge;

  always_comb begin
    ge = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      ge = (lanes_i[l].rem >= lanes_i[l].dsh);
      lanes_d[l].rem = ge ? (lanes_i[l].rem - lanes_i[l].dsh) : lanes_i[l].rem;
      lanes_d[l].dsh = lanes_i[l].dsh >> 1;
      lanes_d[l].quo = {lanes_i[l].quo[QB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_o <= lanes_d;
      side_o  <= side_i;
    end
  end

endmodule

### rtl/rhc_out_stage.sv
// Result assembly, output register and skid register of the converter.
// Depends on rhc_pkg.
module rhc_out_stage
  import rhc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  rhc_lanes_t lanes_i,
  input  rhc_side_t  side_i,
  output logic       en_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rhc_out_t   out_item_o
);

  logic [FIELD_W-1:0] q0, q1, q2, base, wrap;
  rhc_out_t           res;
  rhc_out_t           skid_q;
  logic               skid_valid_q;
  logic               out_fire, push;

  always_comb begin
    q0 = lanes_i[0].quo[FIELD_W-1:0];
    q1 = lanes_i[1].quo[FIELD_W-1:0];
    q2 = lanes_i[2].quo[FIELD_W-1:0];
    case (side_i.sel)
      MAX_GREEN: base = HUE_GREEN_BASE;
      MAX_BLUE:  base = HUE_BLUE_BASE;
      default:   base = '0;
    endcase
    // A red hue only wraps when the truncated offset is nonzero
    wrap = ((side_i.sel == MAX_RED) && (q1 != '0)) ? HUE_FULL : base;
    if (!side_i.to_rgb) begin
      if (side_i.special) begin
        res = '{result_a: '0, result_b: '0, result_c: side_i.v};
      end else begin
        res.result_a = side_i.neg ? (wrap - q1) : (base + q1);
        res.result_b = q0;
        res.result_c = side_i.v;
      end
    end else if (side_i.special) begin
      res = '{result_a: side_i.v, result_b: side_i.v, result_c: side_i.v};
    end else begin
      // p = q0, q = q1, t = q2
      case (side_i.sector)
        3'd0:    res = '{result_a: side_i.v, result_b: q2, result_c: q0};
        3'd1:    res = '{result_a: q1, result_b: side_i.v, result_c: q0};
        3'd2:    res = '{result_a: q0, result_b: side_i.v, result_c: q2};
        3'd3:    res = '{result_a: q0, result_b: q1, result_c: side_i.v};
        3'd4:    res = '{result_a: q2, result_b: q0, result_c: side_i.v};
        default: res = '{result_a: side_i.v, result_b: q0, result_c: q1};
      endcase
    end
  end

  assign en_o     = !skid_valid_q;
  assign out_fire = out_valid_o && !out_stall_i;
  assign push     = en_o && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_o || out_fire) begin
        out_valid_o <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_item_o <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_o || out_fire) begin
        out_item_o <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

endmodule

### rtl/rgb_hsv_convert_top.sv
// Top level of the RGB/HSV pixel converter.
// Depends on rhc_pkg, rhc_prep, rhc_div_cell, rhc_out_stage and assert_macros.svh.
//
// Usage:
//   One pixel per item on the input channel (in_valid_i / in_stall_o / in_item_i).
//   Opcode 0 converts RGB to HSV, opcode 1 converts HSV to RGB; one result item
//   leaves on the output channel (out_valid_o / out_stall_i / out_item_o).
//   Pipeline: the classify stage loads at the accepting edge, then the multiply
//   stage, one cell per quotient bit of the three-lane divider chain, and the
//   output register.
//   Throughput: one item per cycle while the chain is not held by a stall; the
//   divider chain is the pipeline and every cell retires one quotient bit on each
//   lane per cycle as the chain advances.
//   Stall: the output register is backed by a skid register. When the receiver
//   stalls with a result waiting, the next result parks in the skid register and
//   in_stall_o rises the following cycle; the whole chain then holds in place.
//   Reset: all valid bits clear; no pass over any storage is needed, the block
//   takes an item as soon as reset is released.
`include "assert_macros.svh"

module rgb_hsv_convert_top
  import rhc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rhc_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rhc_out_t out_item_o
);

  logic       en;
  logic       chain_valid [QB+1];
  rhc_lanes_t chain_lanes [QB+1];
  rhc_side_t  chain_side  [QB+1];

  // Hold the input whenever the skid register is occupied
  assign in_stall_o = !en;

  rhc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .valid_o (chain_valid[0]),
    .lanes_o (chain_lanes[0]),
    .side_o  (chain_side[0])
  );

  // Divider chain: advance all lanes one quotient bit per cell
  for (genvar i = 0; i < QB; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .lanes_i (chain_lanes[i]),
      .side_i  (chain_side[i]),
      .valid_o (chain_valid[i+1]),
      .lanes_o (chain_lanes[i+1]),
      .side_o  (chain_side[i+1])
    );
  end

  rhc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (chain_valid[QB]),
    .lanes_i     (chain_lanes[QB]),
    .side_i      (chain_side[QB]),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // A parked result always has one ahead of it in the output register
  `RHC_ASSERT_NEVER(a_skid_without_out, clk_i, rst_ni, in_stall_o && !out_valid_o, "skid full with empty output")
  // A stalled receiver keeps the skid register occupied
  `RHC_ASSERT(a_skid_holds, clk_i, rst_ni, in_stall_o && out_stall_i |=> in_stall_o, "skid drained under stall")
  // The skid register fills only behind a stalled result
  `RHC_ASSERT(a_skid_fill_cause, clk_i, rst_ni, $rose(in_stall_o) |-> $past(out_stall_i), "skid filled without stall")

endmodule

### tb/tb_rgb_hsv_convert_top.sv
// Testbench of rgb_hsv_convert_top: drives RGB and HSV pixels and checks each result
// against a bit-exact integer converter kept here. Depends on rhc_pkg and the RTL.
`timescale 1ns / 100ps

class pixel_scoreboard;
  rhc_pkg::rhc_out_t pending_q[$];
  int unsigned       err_cnt;

  function rhc_pkg::rhc_out_t convert(rhc_pkg::rhc_in_t px);
    rhc_pkg::rhc_out_t res;
    longint unsigned cmax, kk, r, g, b, mx, mn, d, mag, h, s, v, sec, f, p, q, t;
    longint signed hs;
    cmax = 65535;
    kk   = cmax * 3840;
    if (px.opcode == rhc_pkg::OP_TO_HSV) begin
      r = px.channel_a; g = px.channel_b; b = px.channel_c;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      res.result_c = mx[15:0];
      if (d == 0) begin
        res.result_a = '0;
        res.result_b = '0;
      end else begin
        res.result_b = 16'((d * cmax) / d == cmax ? (d * cmax) / mx : 0);
        // pick the max channel and the hue offset of its sector
        if (r >= mx) begin
          mag = (g >= b) ? g - b : b - g;
          hs  = (g >= b) ? longint'((mag * 3840) / d) : -longint'((mag * 3840) / d);
        end else if (g >= mx) begin
          mag = (b >= r) ? b - r : r - b;
          hs  = 7680 + ((b >= r) ? longint'((mag * 3840) / d) : -longint'((mag * 3840) / d));
        end else begin
          mag = (r >= g) ? r - g : g - r;
          hs  = 15360 + ((r >= g) ? longint'((mag * 3840) / d) : -longint'((mag * 3840) / d));
        end
        if (hs < 0) hs += 23040;
        res.result_a = 16'(hs);
      end
    end else begin
      h = px.channel_a; s = px.channel_b; v = px.channel_c;
      if (s == 0) begin
        res = '{v[15:0], v[15:0], v[15:0]};
      end else begin
        if (h >= 23040) h = 0;
        sec = h / 3840;
        f   = h % 3840;
        p   = (v * (cmax - s)) / cmax;
        q   = (v * (kk - s * f)) / kk;
        t   = (v * (kk - s * (3840 - f))) / kk;
        case (sec)
          0: res = '{v[15:0], t[15:0], p[15:0]};
          1: res = '{q[15:0], v[15:0], p[15:0]};
          2: res = '{p[15:0], v[15:0], t[15:0]};
          3: res = '{p[15:0], q[15:0], v[15:0]};
          4: res = '{t[15:0], p[15:0], v[15:0]};
          default: res = '{v[15:0], p[15:0], q[15:0]};
        endcase
      end
    end
    return res;
  endfunction

  function void note_pixel(rhc_pkg::rhc_in_t px);
    pending_q.insert(pending_q.size(), convert(px));
  endfunction

  function void check_result(rhc_pkg::rhc_out_t got);
    rhc_pkg::rhc_out_t exp;
    if (pending_q.size() == 0) begin
      $error("unexpected result %h", got);
      err_cnt++;
      return;
    end
    exp = pending_q.pop_front();
    if (got.result_a !== exp.result_a) begin
      $error("result_a expected %0d actual %0d", exp.result_a, got.result_a);
      err_cnt++;
    end
    if (got.result_b !== exp.result_b) begin
      $error("result_b expected %0d actual %0d", exp.result_b, got.result_b);
      err_cnt++;
    end
    if (got.result_c !== exp.result_c) begin
      $error("result_c expected %0d actual %0d", exp.result_c, got.result_c);
      err_cnt++;
    end
  endfunction
endclass

module tb_rgb_hsv_convert_top;
  import rhc_pkg::*;

  localparam int LATENCY   = 18;
  localparam int MAX_CYCLES = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  rhc_in_t  in_item_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  rhc_out_t out_item_o;

  pixel_scoreboard sb = new();

  // Idle odds in percent; the phases below retune them.
  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 71;
  int unsigned hold_off_cycles = 0;
  int unsigned cycle_cnt = 0;
  bit          stim_done = 1'b0;

  rgb_hsv_convert_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Offer one item; hold it until the edge that takes it, then return at the falling
  // edge with valid still high: the next call or the caller drops it.
  task automatic send_pixel(input rhc_in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(px);
    @(negedge clk_i);
  endtask

  task automatic send_rgb(input logic [15:0] r, g, b);
    send_pixel('{OP_TO_HSV, r, g, b});
  endtask

  task automatic send_hsv(input logic [15:0] h, s, v);
    send_pixel('{OP_TO_RGB, h, s, v});
  endtask

  // Random field values lean toward the edges so every bit flips and ties occur.
  function automatic logic [15:0] pick_ch();
    case ($urandom_range(5))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom_range(255));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random();
    logic [15:0] a, b, c;
    a = pick_ch(); b = pick_ch(); c = pick_ch();
    if ($urandom_range(1)) begin
      // Mostly in-range hue; the RGB branch sometimes ties two channels.
      if ($urandom_range(9) != 0) a = 16'($urandom_range(23039));
      send_hsv(a, b, c);
    end else begin
      if ($urandom_range(7) == 0) b = a;
      send_rgb(a, b, c);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: stall at random, or hold off for a long stretch on request.
  always @(negedge clk_i) begin
    if (hold_off_cycles != 0) begin
      out_stall_i     <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check each accepted result at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, gray, each max channel, negative hue wrap,
    // zero saturation, every sector and out-of-range hue.
    send_rgb(16'h0000, 16'h0000, 16'h0000);
    send_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_rgb(16'h8000, 16'h8000, 16'h8000);
    send_rgb(16'hFFFF, 16'h0000, 16'h0000);
    send_rgb(16'hFFFF, 16'h0000, 16'h0001);
    send_rgb(16'h0000, 16'hFFFF, 16'h0000);
    send_rgb(16'h0001, 16'hFFFF, 16'h0000);
    send_rgb(16'h0000, 16'h0000, 16'hFFFF);
    send_rgb(16'h0000, 16'h0001, 16'hFFFF);
    send_rgb(16'h1234, 16'hABCD, 16'h5555);
    send_hsv(16'd1000, 16'h0000, 16'hFFFF);
    send_hsv(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_hsv(16'd23040, 16'h8000, 16'h9000);
    send_hsv(16'd23039, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_hsv(16'(i * 3840 + 1919), 16'hC000, 16'hFFFF);
    send_hsv(16'd0, 16'hFFFF, 16'h0000);
    send_hsv(16'd3839, 16'h0001, 16'h0001);

    for (int i = 0; i < 230; i++) send_random();

    // Long receiver hold-off while items keep coming: fill and back up the chain.
    hold_off_cycles = 80;
    for (int i = 0; i < 30; i++) send_random();
    wait_drained();

    send_idle_pct = 71;
    recv_idle_pct = 12;
    for (int i = 0; i < 230; i++) send_random();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 210; i++) send_random();
    in_valid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
    if (sb.err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/rhc_pkg.sv
rtl/rhc_prep.sv
rtl/rhc_div_cell.sv
rtl/rhc_out_stage.sv
rtl/rgb_hsv_convert_top.sv
tb/tb_rgb_hsv_convert_top.sv
